// ----- design/qrs_pkg.sv -----
// qrs_pkg: shared types and constants for the quadratic root solver
// no dependencies
`timescale 1ns / 1ps
package qrs_pkg;
   localparam int RES_WIDTH = 32;
   localparam int KIND_WIDTH = 3;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_DISTINCT     = 3'd0,
      KIND_EQUAL        = 3'd1,
      KIND_COMPLEX      = 3'd2,
      KIND_LINEAR       = 3'd3,
      KIND_INCONSISTENT = 3'd4,
      KIND_IDENTITY     = 3'd5
   } kind_type;
endpackage

// ----- design/qrs_isqrt.sv -----
// qrs_isqrt: pipelined restoring integer square root, one result bit per stage
// depends on nothing; carries a user tag alongside each operand
`timescale 1ns / 1ps
module qrs_isqrt #(
   parameter int IN_WIDTH  = 100,
   parameter int TAG_WIDTH = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [IN_WIDTH-1:0]       in_rad,
   input  logic [TAG_WIDTH-1:0]      in_tag,
   output logic                      out_valid,
   output logic [(IN_WIDTH+1)/2-1:0] out_root,
   output logic [TAG_WIDTH-1:0]      out_tag
);
   localparam int RW = (IN_WIDTH + 1) / 2;
   localparam int PW = 2 * RW;
   localparam int EW = RW + 2;

   logic [RW:0]           vld_ff;
   logic [PW-1:0]         rad_ff  [RW+1];
   logic [EW-1:0]         rem_ff  [RW+1];
   logic [RW-1:0]         root_ff [RW+1];
   logic [TAG_WIDTH-1:0]  tag_ff  [RW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[RW-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      rad_ff[0]  <= PW'(in_rad);
      rem_ff[0]  <= '0;
      root_ff[0] <= '0;
      tag_ff[0]  <= in_tag;
   end

   for (genvar i = 0; i < RW; i++) begin : g_step
      logic [EW-1:0] rem_in;
      logic [EW-1:0] trial_in;
      always_comb begin
         rem_in   = {rem_ff[i][EW-3:0], rad_ff[i][PW-1 -: 2]};
         trial_in = {root_ff[i], 2'b01};
      end
      always_ff @(posedge clock) begin
         rad_ff[i+1] <= {rad_ff[i][PW-3:0], 2'b00};
         tag_ff[i+1] <= tag_ff[i];
         if (rem_in >= trial_in) begin
            rem_ff[i+1]  <= rem_in - trial_in;
            root_ff[i+1] <= {root_ff[i][RW-2:0], 1'b1};
         end else begin
            rem_ff[i+1]  <= rem_in;
            root_ff[i+1] <= {root_ff[i][RW-2:0], 1'b0};
         end
      end
   end

   assign out_valid = vld_ff[RW];
   assign out_root  = root_ff[RW];
   assign out_tag   = tag_ff[RW];
endmodule

// ----- design/qrs_divsat.sv -----
// qrs_divsat: pipelined signed divider, truncating, saturated to 32 bits
// depends on qrs_pkg; one quotient bit per stage
`timescale 1ns / 1ps
module qrs_divsat #(
   parameter int NUM_WIDTH = 66,
   parameter int DEN_WIDTH = 34
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic signed [NUM_WIDTH-1:0]   in_num,
   input  logic signed [DEN_WIDTH-1:0]   in_den,
   output logic                          out_valid,
   output logic [qrs_pkg::RES_WIDTH-1:0] out_quo,
   output logic                          out_sat
);
   import qrs_pkg::*;

   // quotient bits beyond 33 only matter as overflow
   localparam int QW = 34;
   localparam int MW = (NUM_WIDTH > QW) ? NUM_WIDTH : QW + 1;
   localparam int RW = DEN_WIDTH + 1;

   logic [QW:0]           vld_ff;
   logic [MW-1:0]         num_ff [QW+1];
   logic [DEN_WIDTH-1:0]  den_ff [QW+1];
   logic [RW-1:0]         rem_ff [QW+1];
   logic [QW-1:0]         quo_ff [QW+1];
   logic                  neg_ff [QW+1];
   logic                  valid_ff;
   logic [RES_WIDTH-1:0]  res_ff;
   logic                  sat_ff;

   logic [MW-1:0]        nmag_in;
   logic [DEN_WIDTH-1:0] dmag_in;
   logic [MW-1:0]        high_in;
   logic                 ovf_in;

   always_comb begin
      nmag_in = in_num[NUM_WIDTH-1] ? MW'(-in_num) : MW'(in_num);
      dmag_in = in_den[DEN_WIDTH-1] ? DEN_WIDTH'(-in_den) : DEN_WIDTH'(in_den);
      // overflow if quotient >= 2^QW, i.e. num >= den << QW
      high_in = nmag_in >> QW;
      ovf_in  = high_in >= MW'(dmag_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         vld_ff   <= {vld_ff[QW-1:0], in_valid};
         valid_ff <= vld_ff[QW];
      end
   end

   logic ovf_pipe_ff [QW+1];
   always_ff @(posedge clock) begin
      num_ff[0]      <= nmag_in << (MW - QW);
      den_ff[0]      <= dmag_in;
      rem_ff[0]      <= RW'(nmag_in >> QW);
      quo_ff[0]      <= '0;
      neg_ff[0]      <= in_num[NUM_WIDTH-1] ^ in_den[DEN_WIDTH-1];
      ovf_pipe_ff[0] <= ovf_in;
   end

   for (genvar i = 0; i < QW; i++) begin : g_step
      logic [RW:0] rem_in;
      always_comb begin
         rem_in = {rem_ff[i], num_ff[i][MW-1]};
      end
      always_ff @(posedge clock) begin
         num_ff[i+1]      <= {num_ff[i][MW-2:0], 1'b0};
         den_ff[i+1]      <= den_ff[i];
         neg_ff[i+1]      <= neg_ff[i];
         ovf_pipe_ff[i+1] <= ovf_pipe_ff[i];
         if (rem_in >= (RW+1)'(den_ff[i])) begin
            rem_ff[i+1] <= RW'(rem_in - (RW+1)'(den_ff[i]));
            quo_ff[i+1] <= {quo_ff[i][QW-2:0], 1'b1};
         end else begin
            rem_ff[i+1] <= RW'(rem_in);
            quo_ff[i+1] <= {quo_ff[i][QW-2:0], 1'b0};
         end
      end
   end

   logic [QW-1:0]        q_in;
   logic                 big_in;
   logic [RES_WIDTH-1:0] res_in;
   logic                 sat_in;
   always_comb begin
      q_in   = quo_ff[QW];
      big_in = ovf_pipe_ff[QW];
      sat_in = 1'b0;
      if (neg_ff[QW]) begin
         if (big_in || q_in > QW'(34'h080000000)) begin
            res_in = 32'h80000000;
            sat_in = 1'b1;
         end else begin
            res_in = RES_WIDTH'(-q_in);
         end
      end else begin
         if (big_in || q_in > QW'(34'h07FFFFFFF)) begin
            res_in = 32'h7FFFFFFF;
            sat_in = 1'b1;
         end else begin
            res_in = RES_WIDTH'(q_in);
         end
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      sat_ff <= sat_in;
   end

   assign out_valid = valid_ff;
   assign out_quo   = res_ff;
   assign out_sat   = sat_ff;
endmodule

// ----- design/quadratic_root_solver.sv -----
// quadratic_root_solver: fully pipelined fixed-point quadratic solver
// depends on qrs_pkg, qrs_isqrt, qrs_divsat
//
// usage: drive req_coef_* with start high; busy is always low, so one
// transaction is taken every cycle that start is high. each transaction
// gives exactly one result, marked by rsp_valid high for one cycle;
// results come out in the order taken.
// path: products and discriminant, then square root (one root bit per
// stage), numerator forming, division (one quotient bit per stage plus
// saturation), and the output register.
// throughput: one transaction per cycle, set by the fully unrolled root and
// divider pipelines.
// reset clears the valid bits of every stage; data registers are not reset.
// the receiver cannot stall, so nothing is ever held back.
`timescale 1ns / 1ps
module quadratic_root_solver #(
   parameter int COEF_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COEF_WIDTH-1:0]  req_coef_quad,
   input  logic signed [COEF_WIDTH-1:0]  req_coef_lin,
   input  logic signed [COEF_WIDTH-1:0]  req_coef_const,
   output logic                          rsp_valid,
   output logic [qrs_pkg::KIND_WIDTH-1:0] rsp_root_kind,
   output logic signed [qrs_pkg::RES_WIDTH-1:0] rsp_first_real,
   output logic signed [qrs_pkg::RES_WIDTH-1:0] rsp_first_imag,
   output logic signed [qrs_pkg::RES_WIDTH-1:0] rsp_second_real,
   output logic signed [qrs_pkg::RES_WIDTH-1:0] rsp_second_imag,
   output logic                          rsp_saturated
);
   import qrs_pkg::*;

   localparam int CW  = COEF_WIDTH;
   localparam int PW  = 2 * CW + 3;           // signed discriminant width
   localparam int DW  = 2 * CW + 2;           // magnitude of discriminant
   localparam int SQW = DW + 32;              // radicand width
   localparam int SW  = (SQW + 1) / 2;        // root width
   localparam int NW  = CW + 17 + 2;          // -b*65536 +- s, signed
   localparam int NUMW = (NW > SW + 2) ? NW : SW + 2;
   localparam int DENW = CW + 2;
   localparam int TW  = KIND_WIDTH + 3 * CW;

   logic accept;
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // stage 1: products
   logic                  s1_vld_ff;
   logic signed [CW-1:0]  s1_a_ff, s1_b_ff, s1_c_ff;
   logic signed [2*CW-1:0] s1_bb_ff, s1_ac_ff;
   always_ff @(posedge clock) begin
      if (reset) s1_vld_ff <= 1'b0;
      else       s1_vld_ff <= accept;
      s1_a_ff  <= req_coef_quad;
      s1_b_ff  <= req_coef_lin;
      s1_c_ff  <= req_coef_const;
      s1_bb_ff <= req_coef_lin * req_coef_lin;
      s1_ac_ff <= req_coef_quad * req_coef_const;
   end

   // stage 2: discriminant and classification
   logic signed [PW-1:0] disc_in;
   kind_type             kind_in;
   always_comb begin
      disc_in = PW'(s1_bb_ff) - (PW'(s1_ac_ff) <<< 2);
      if (s1_a_ff == '0) begin
         if (s1_b_ff != '0)      kind_in = KIND_LINEAR;
         else if (s1_c_ff != '0) kind_in = KIND_INCONSISTENT;
         else                    kind_in = KIND_IDENTITY;
      end else if (disc_in[PW-1]) begin
         kind_in = KIND_COMPLEX;
      end else if (disc_in == '0) begin
         kind_in = KIND_EQUAL;
      end else begin
         kind_in = KIND_DISTINCT;
      end
   end

   logic                 s2_vld_ff;
   logic [DW-1:0]        s2_dmag_ff;
   logic [TW-1:0]        s2_tag_ff;
   always_ff @(posedge clock) begin
      if (reset) s2_vld_ff <= 1'b0;
      else       s2_vld_ff <= s1_vld_ff;
      s2_dmag_ff <= disc_in[PW-1] ? DW'(-disc_in) : DW'(disc_in);
      s2_tag_ff  <= {kind_in, s1_a_ff, s1_b_ff, s1_c_ff};
   end

   logic          sq_vld;
   logic [SW-1:0] sq_root;
   logic [TW-1:0] sq_tag;
   qrs_isqrt #(.IN_WIDTH(SQW), .TAG_WIDTH(TW)) u_isqrt (
      .clock(clock), .reset(reset),
      .in_valid(s2_vld_ff), .in_rad({s2_dmag_ff, 32'h0}), .in_tag(s2_tag_ff),
      .out_valid(sq_vld), .out_root(sq_root), .out_tag(sq_tag)
   );

   // stage 3: numerators and denominators for four dividers
   kind_type             t_kind;
   logic signed [CW-1:0] t_a, t_b, t_c;
   assign t_kind = kind_type'(sq_tag[TW-1 -: KIND_WIDTH]);
   assign t_a    = sq_tag[3*CW-1 -: CW];
   assign t_b    = sq_tag[2*CW-1 -: CW];
   assign t_c    = sq_tag[CW-1:0];

   logic signed [NUMW-1:0] nb_in, s_in;
   logic signed [NUMW-1:0] n0_in, n1_in, n2_in, n3_in;
   logic signed [DENW-1:0] den_in;
   always_comb begin
      nb_in  = -(NUMW'(t_b) <<< 16);
      s_in   = NUMW'({1'b0, sq_root});
      den_in = DENW'(t_a) <<< 1;
      n0_in  = nb_in + s_in;
      n1_in  = '0;
      n2_in  = nb_in - s_in;
      n3_in  = '0;
      if (t_kind == KIND_COMPLEX) begin
         n0_in = nb_in;
         n1_in = s_in;
         n2_in = nb_in;
         n3_in = -s_in;
      end else if (t_kind == KIND_LINEAR) begin
         n0_in  = -(NUMW'(t_c) <<< 16);
         n2_in  = n0_in;
         den_in = DENW'(t_b);
      end else if (t_kind == KIND_INCONSISTENT || t_kind == KIND_IDENTITY) begin
         n0_in  = '0;
         n2_in  = '0;
         den_in = DENW'(1);
      end
   end

   logic                   s3_vld_ff;
   logic signed [NUMW-1:0] s3_n_ff [4];
   logic signed [DENW-1:0] s3_den_ff;
   always_ff @(posedge clock) begin
      if (reset) s3_vld_ff <= 1'b0;
      else       s3_vld_ff <= sq_vld;
      s3_n_ff[0] <= n0_in;
      s3_n_ff[1] <= n1_in;
      s3_n_ff[2] <= n2_in;
      s3_n_ff[3] <= n3_in;
      s3_den_ff  <= den_in;
   end

   // kind rides in a small delay line matched to the divider
   localparam int DLAT = 37;
   kind_type kind_dly_ff [DLAT];
   always_ff @(posedge clock) begin
      kind_dly_ff[0] <= t_kind;
      for (int i = 1; i < DLAT; i++) kind_dly_ff[i] <= kind_dly_ff[i-1];
   end

   logic [3:0]           dv_vld;
   logic [RES_WIDTH-1:0] dv_quo [4];
   logic [3:0]           dv_sat;
   for (genvar k = 0; k < 4; k++) begin : g_div
      qrs_divsat #(.NUM_WIDTH(NUMW), .DEN_WIDTH(DENW)) u_div (
         .clock(clock), .reset(reset),
         .in_valid(s3_vld_ff), .in_num(s3_n_ff[k]), .in_den(s3_den_ff),
         .out_valid(dv_vld[k]), .out_quo(dv_quo[k]), .out_sat(dv_sat[k])
      );
   end

   // output register
   kind_type k_out;
   logic     rsp_valid_ff, rsp_sat_ff;
   logic [KIND_WIDTH-1:0] rsp_kind_ff;
   logic [RES_WIDTH-1:0]  rsp_r0_ff, rsp_i0_ff, rsp_r1_ff, rsp_i1_ff;
   assign k_out = kind_dly_ff[DLAT-1];
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= dv_vld[0];
      rsp_kind_ff <= k_out;
      rsp_r0_ff   <= dv_quo[0];
      rsp_i0_ff   <= dv_quo[1];
      rsp_r1_ff   <= dv_quo[2];
      rsp_i1_ff   <= dv_quo[3];
      if (k_out == KIND_COMPLEX)
         rsp_sat_ff <= |dv_sat;
      else if (k_out == KIND_INCONSISTENT || k_out == KIND_IDENTITY)
         rsp_sat_ff <= 1'b0;
      else
         rsp_sat_ff <= dv_sat[0] | dv_sat[2];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_root_kind   = rsp_kind_ff;
   assign rsp_first_real  = rsp_r0_ff;
   assign rsp_first_imag  = rsp_i0_ff;
   assign rsp_second_real = rsp_r1_ff;
   assign rsp_second_imag = rsp_i1_ff;
   assign rsp_saturated   = rsp_sat_ff;
endmodule

// ----- design/qrs_checker.sv -----
// qrs_checker: port-level checks for quadratic_root_solver
// depends on qrs_pkg; bound to the top level below
`timescale 1ns / 1ps
module qrs_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           busy,
   input logic                           rsp_valid,
   input logic [qrs_pkg::KIND_WIDTH-1:0] rsp_root_kind,
   input logic [qrs_pkg::RES_WIDTH-1:0]  rsp_first_imag,
   input logic [qrs_pkg::RES_WIDTH-1:0]  rsp_second_real,
   input logic [qrs_pkg::RES_WIDTH-1:0]  rsp_first_real,
   input logic                           rsp_saturated
);
   import qrs_pkg::*;

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");
   a_real_no_imag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_root_kind == KIND_DISTINCT || rsp_root_kind == KIND_EQUAL
      || rsp_root_kind == KIND_LINEAR) |-> rsp_first_imag == '0)
      else $error("imaginary part on real root");
   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_root_kind == KIND_INCONSISTENT
      || rsp_root_kind == KIND_IDENTITY) |-> rsp_first_real == '0 && !rsp_saturated)
      else $error("degenerate case not zero");
   a_linear_equal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_root_kind == KIND_LINEAR |-> rsp_first_real == rsp_second_real)
      else $error("linear roots differ");
endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
   .clock(clock), .reset(reset), .busy(busy), .rsp_valid(rsp_valid),
   .rsp_root_kind(rsp_root_kind), .rsp_first_imag(rsp_first_imag),
   .rsp_second_real(rsp_second_real), .rsp_first_real(rsp_first_real),
   .rsp_saturated(rsp_saturated)
);

// ----- sim/testbench.sv -----
// testbench: checks quadratic_root_solver against an in-bench root predictor
// depends on qrs_pkg and quadratic_root_solver
`timescale 1ns / 1ps
module testbench;
   import qrs_pkg::*;

   localparam int CW = 16;
   localparam int LATENCY = 2 + CW + 18 + 1 + 36 + 1;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] r1;
      logic [31:0] i1;
      logic [31:0] r2;
      logic [31:0] i2;
      logic        sat;
   } roots_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic signed [CW-1:0] req_coef_quad = '0, req_coef_lin = '0, req_coef_const = '0;
   logic rsp_valid;
   logic [KIND_WIDTH-1:0] rsp_root_kind;
   logic signed [31:0] rsp_first_real, rsp_first_imag, rsp_second_real, rsp_second_imag;
   logic rsp_saturated;

   roots_type expected_roots[$];
   int mismatches = 0;

   quadratic_root_solver #(.COEF_WIDTH(CW)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_coef_quad(req_coef_quad), .req_coef_lin(req_coef_lin),
      .req_coef_const(req_coef_const), .rsp_valid(rsp_valid),
      .rsp_root_kind(rsp_root_kind), .rsp_first_real(rsp_first_real),
      .rsp_first_imag(rsp_first_imag), .rsp_second_real(rsp_second_real),
      .rsp_second_imag(rsp_second_imag), .rsp_saturated(rsp_saturated)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic logic [31:0] quot_sat(longint signed num, longint signed den,
                                             ref logic sat);
      logic signed [127:0] q;
      q = 128'(num) / 128'(den);
      if (q > 128'sh7FFFFFFF) begin
         sat = 1;
         return 32'h7FFFFFFF;
      end
      if (q < -128'sh80000000) begin
         sat = 1;
         return 32'h80000000;
      end
      return q[31:0];
   endfunction

   function automatic logic [63:0] isqrt(logic [127:0] n);
      logic [63:0] r, t;
      r = 0;
      for (int i = 63; i >= 0; i--) begin
         t = r | (64'd1 << i);
         if (128'(t) * 128'(t) <= n) r = t;
      end
      return r;
   endfunction

   function automatic roots_type solve_roots(logic signed [CW-1:0] qa,
                                             logic signed [CW-1:0] qb,
                                             logic signed [CW-1:0] qc);
      roots_type res;
      longint signed a, b, c, s, den, nb;
      logic signed [127:0] disc;
      logic [127:0] mag;
      logic sat;
      a = qa;
      b = qb;
      c = qc;
      res = '0;
      sat = 0;
      if (a == 0) begin
         if (b != 0) begin
            res.kind = KIND_LINEAR;
            res.r1 = quot_sat(-c * 65536, b, sat);
            res.r2 = res.r1;
         end else begin
            res.kind = (c != 0) ? KIND_INCONSISTENT : KIND_IDENTITY;
         end
      end else begin
         disc = 128'(b) * 128'(b) - 128'sd4 * 128'(a) * 128'(c);
         mag = (disc < 0) ? -disc : disc;
         s = longint'(isqrt(mag << 32));
         den = 2 * a;
         nb = -b * 65536;
         if (disc >= 0) begin
            res.kind = (disc > 0) ? KIND_DISTINCT : KIND_EQUAL;
            res.r1 = quot_sat(nb + s, den, sat);
            res.r2 = quot_sat(nb - s, den, sat);
         end else begin
            res.kind = KIND_COMPLEX;
            res.r1 = quot_sat(nb, den, sat);
            res.r2 = res.r1;
            res.i1 = quot_sat(s, den, sat);
            res.i2 = quot_sat(-s, den, sat);
         end
      end
      res.sat = sat;
      return res;
   endfunction

   always @(posedge clock) begin
      roots_type exp_r, got;
      if (!reset && rsp_valid) begin
         got = {kind_type'(rsp_root_kind), rsp_first_real, rsp_first_imag,
                rsp_second_real, rsp_second_imag, rsp_saturated};
         if (expected_roots.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transaction %p", got);
         end else begin
            exp_r = expected_roots.pop_front();
            if (got !== exp_r) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch exp %p got %p", exp_r, got);
            end
         end
      end
   end

   // start stays high across back-to-back transactions
   task automatic send_coefs(logic [CW-1:0] qa, logic [CW-1:0] qb, logic [CW-1:0] qc,
                             bit may_idle = 1'b1);
      int gap;
      gap = may_idle ? $urandom_range(0, 12) : 0;
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_coef_quad <= qa;
      req_coef_lin <= qb;
      req_coef_const <= qc;
      do @(posedge clock); while (busy);
      expected_roots.push_back(solve_roots(qa, qb, qc));
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      start <= 1'b0;
      while (expected_roots.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
   endtask

   task automatic test_directed();
      logic [CW-1:0] ext[5] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000};
      send_coefs('0, '0, '0);
      send_coefs('0, '0, 16'h0100);
      send_coefs('0, 16'h0001, 16'h7FFF);
      send_coefs('0, 16'h0200, 16'h0100);
      send_coefs(16'h0100, 16'h0200, 16'h0100);
      send_coefs(16'h0100, '0, 16'h0100);
      send_coefs(16'hFF00, '0, 16'hFF00);
      send_coefs(16'h0100, '0, 16'hFF00);
      send_coefs(16'h0001, 16'h7FFF, 16'h0001);
      send_coefs(16'h8000, 16'h8000, 16'h8000);
      send_coefs(16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_coefs(16'h0001, 16'h8000, 16'h7FFF);
      for (int i = 0; i < 12; i++)
         send_coefs(ext[$urandom_range(0, 4)], ext[$urandom_range(0, 4)],
                    ext[$urandom_range(0, 4)], 1'b0);
   endtask

   function automatic logic [CW-1:0] pick_coef();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return CW'($urandom_range(0, 15)) << 8;
         2: return -(CW'($urandom_range(0, 15)) << 8);
         3: return CW'($urandom_range(0, 7));
         default: return CW'($urandom);
      endcase
   endfunction

   task automatic test_random(int count);
      for (int i = 0; i < count; i++)
         send_coefs(pick_coef(), pick_coef(), pick_coef());
   endtask

   task automatic test_back_to_back(int count);
      for (int i = 0; i < count; i++)
         send_coefs(CW'($urandom), CW'($urandom), CW'($urandom), 1'b0);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      test_directed();
      drain();
      test_random(400);
      drain();
      test_back_to_back(150);
      test_random(276);
      drain();
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0 && expected_roots.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

// ----- quadratic_root_solver.f -----
design/qrs_pkg.sv
design/qrs_isqrt.sv
design/qrs_divsat.sv
design/quadratic_root_solver.sv
design/qrs_checker.sv
sim/testbench.sv
